FILE: src/lscd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_pkg
// Shared types, constants and codes of the LED strip command decoder.
// ----------------------------------------------------------------------------
package lscd_pkg;

    // Strip geometry
    localparam int PIXEL_COUNT = 60;
    localparam int PIX_AW      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [15:0] PIX_LIMIT = 16'(PIXEL_COUNT);
    localparam logic [15:0] PIX_LAST  = 16'(PIXEL_COUNT - 1);
    localparam int RGB_W       = 24;

    // Stream widths
    localparam int S_TDATA_W = 16;   // data_byte, read_index
    localparam int M_TDATA_W = 40;   // 35 payload bits padded to whole bytes

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RLE_START  = 1'd1;
    localparam logic [7:0]           RLE_START_RST  = 8'd1;

    // Input opcodes (tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Header
    localparam logic [15:0] SIGNATURE = 16'h504C;
    localparam logic [7:0]  CMD_FILL  = 8'd0;
    localparam logic [7:0]  CMD_PIXEL = 8'd1;
    localparam logic [7:0]  CMD_LEVEL = 8'd2;
    localparam logic [7:0]  CMD_RLE   = 8'd3;
    localparam logic [2:0]  HDR_BYTES = 3'd5;
    localparam logic [2:0]  COLOR_BYTES = 3'd3;
    localparam logic [2:0]  CHUNK_BYTES = 3'd4;

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COLOR,
        PH_PIXEL,
        PH_LEVEL,
        PH_RLE
    } parse_phase_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_READ,
        K_FILL,
        K_SET,
        K_RUN
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SET,
        BK_READ,
        BK_FILL,
        BK_RUN,
        BK_FINISH
    } back_state_t;

    // One work item from the parser to the frame engine
    typedef struct packed {
        cmd_kind_t        kind;
        logic [15:0]      index;      // pixel, run start or read index
        logic [7:0]       run;
        logic [RGB_W-1:0] rgb;
        logic             updated;
        logic             bad_sig;
        logic [7:0]       brightness;
    } queue_entry_t;

endpackage

FILE: src/lscd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lscd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lscd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_front
// Byte parser: assembles headers and payloads and issues one work item per
// accepted beat to the command queue.
// ----------------------------------------------------------------------------
module lscd_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lscd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             cfg_we,
    input  logic [lscd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lscd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             q_full,
    output logic                             q_push,
    output lscd_pkg::queue_entry_t           q_entry
);
    import lscd_pkg::*;

    parse_phase_t phase_reg, phase_next;
    logic [2:0]   byte_counter_reg, byte_counter_next;
    logic [39:0]  header_shift_reg, header_shift_next;
    logic [31:0]  payload_shift_reg, payload_shift_next;
    logic [13:0]  runs_remaining_reg, runs_remaining_next;
    logic [15:0]  next_write_index_reg, next_write_index_next;
    logic [7:0]   brightness_reg, brightness_next;
    logic         big_endian_reg;
    logic [7:0]   rle_start_reg;

    logic         accept;
    logic [7:0]   data_byte;
    logic [7:0]   read_index;
    logic [39:0]  hdr_new;
    logic [31:0]  pay_new;
    logic [2:0]   cnt_inc;
    logic [15:0]  sig;
    logic [15:0]  len;
    logic [16:0]  run_sum;
    logic [15:0]  run_end;
    logic [13:0]  runs_dec;

    cmd_kind_t        ent_kind;
    logic [15:0]      ent_index;
    logic [7:0]       ent_run;
    logic [RGB_W-1:0] ent_rgb;
    logic             ent_updated;
    logic             ent_bad;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign data_byte  = s_tdata[7:0];
    assign read_index = s_tdata[15:8];

    assign hdr_new = {header_shift_reg[31:0], data_byte};
    assign pay_new = {payload_shift_reg[23:0], data_byte};
    assign cnt_inc = byte_counter_reg + 3'd1;
    assign sig = big_endian_reg ? hdr_new[39:24] : {hdr_new[31:24], hdr_new[39:32]};
    assign len = big_endian_reg ? hdr_new[15:0]  : {hdr_new[7:0], hdr_new[15:8]};
    assign run_sum  = {1'b0, next_write_index_reg} + {9'd0, pay_new[31:24]};
    // saturate the write position at the top of its range
    assign run_end  = run_sum[16] ? 16'hFFFF : run_sum[15:0];
    assign runs_dec = (runs_remaining_reg != 14'd0) ? runs_remaining_reg - 14'd1
                                                    : runs_remaining_reg;

    // Parser state and decode
    always_comb begin
        phase_next            = phase_reg;
        byte_counter_next     = byte_counter_reg;
        header_shift_next     = header_shift_reg;
        payload_shift_next    = payload_shift_reg;
        runs_remaining_next   = runs_remaining_reg;
        next_write_index_next = next_write_index_reg;
        brightness_next       = brightness_reg;
        ent_kind    = K_NONE;
        ent_index   = 16'd0;
        ent_run     = 8'd0;
        ent_rgb     = '0;
        ent_updated = 1'b0;
        ent_bad     = 1'b0;

        if (accept) begin
            if (s_tuser == OP_READ) begin
                ent_kind  = K_READ;
                ent_index = {8'd0, read_index};
            end else begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        header_shift_next = hdr_new;
                        byte_counter_next = cnt_inc;
                        if (cnt_inc >= HDR_BYTES) begin
                            byte_counter_next  = 3'd0;
                            payload_shift_next = 32'd0;
                            if (sig != SIGNATURE) begin
                                ent_bad = 1'b1;
                            end else begin
                                unique case (hdr_new[23:16])
                                    CMD_FILL:  phase_next = PH_COLOR;
                                    CMD_PIXEL: phase_next = PH_PIXEL;
                                    CMD_LEVEL: phase_next = PH_LEVEL;
                                    CMD_RLE: begin
                                        runs_remaining_next   = len[15:2];
                                        next_write_index_next = {8'd0, rle_start_reg};
                                        if (len[15:2] == 14'd0) begin
                                            ent_updated = 1'b1;
                                        end else begin
                                            phase_next = PH_RLE;
                                        end
                                    end
                                    default: ;  // unknown command: no payload
                                endcase
                            end
                        end
                    end
                    PH_LEVEL: begin
                        payload_shift_next = pay_new;
                        brightness_next    = data_byte;
                        ent_updated        = 1'b1;
                        phase_next         = PH_HEADER;
                        byte_counter_next  = 3'd0;
                    end
                    PH_COLOR: begin
                        payload_shift_next = pay_new;
                        byte_counter_next  = cnt_inc;
                        if (cnt_inc >= COLOR_BYTES) begin
                            ent_kind          = K_FILL;
                            ent_rgb           = pay_new[23:0];
                            ent_updated       = 1'b1;
                            phase_next        = PH_HEADER;
                            byte_counter_next = 3'd0;
                        end
                    end
                    PH_PIXEL: begin
                        payload_shift_next = pay_new;
                        byte_counter_next  = cnt_inc;
                        if (cnt_inc >= CHUNK_BYTES) begin
                            ent_kind          = K_SET;
                            ent_index         = {8'd0, pay_new[31:24]};
                            ent_rgb           = pay_new[23:0];
                            ent_updated       = 1'b1;
                            phase_next        = PH_HEADER;
                            byte_counter_next = 3'd0;
                        end
                    end
                    PH_RLE: begin
                        payload_shift_next = pay_new;
                        byte_counter_next  = cnt_inc;
                        if (cnt_inc >= CHUNK_BYTES) begin
                            ent_kind              = K_RUN;
                            ent_index             = next_write_index_reg;
                            ent_run               = pay_new[31:24];
                            ent_rgb               = pay_new[23:0];
                            next_write_index_next = run_end;
                            byte_counter_next     = 3'd0;
                            payload_shift_next    = 32'd0;
                            runs_remaining_next   = runs_dec;
                            if (runs_dec == 14'd0) begin
                                ent_updated = 1'b1;
                                phase_next  = PH_HEADER;
                            end
                        end
                    end
                    default: begin
                        payload_shift_next = pay_new;
                        phase_next         = PH_HEADER;
                        byte_counter_next  = 3'd0;
                    end
                endcase
            end
        end
    end

    // Work item towards the queue
    always_comb begin
        q_push             = accept;
        q_entry.kind       = ent_kind;
        q_entry.index      = ent_index;
        q_entry.run        = ent_run;
        q_entry.rgb        = ent_rgb;
        q_entry.updated    = ent_updated;
        q_entry.bad_sig    = ent_bad;
        q_entry.brightness = brightness_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= PH_HEADER;
            byte_counter_reg     <= 3'd0;
            header_shift_reg     <= 40'd0;
            payload_shift_reg    <= 32'd0;
            runs_remaining_reg   <= 14'd0;
            next_write_index_reg <= 16'd0;
            brightness_reg       <= 8'd0;
            big_endian_reg       <= 1'b0;
            rle_start_reg        <= RLE_START_RST;
        end else begin
            phase_reg            <= phase_next;
            byte_counter_reg     <= byte_counter_next;
            header_shift_reg     <= header_shift_next;
            payload_shift_reg    <= payload_shift_next;
            runs_remaining_reg   <= runs_remaining_next;
            next_write_index_reg <= next_write_index_next;
            brightness_reg       <= brightness_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BIG_ENDIAN: big_endian_reg <= cfg_wdata[0];
                    CFG_RLE_START:  rle_start_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: src/lscd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_queue
// Small FIFO of work items between the parser and the frame engine.
// ----------------------------------------------------------------------------
module lscd_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lscd_pkg::queue_entry_t  push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    valid,
    output lscd_pkg::queue_entry_t  head_entry
);
    import lscd_pkg::*;

    queue_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0]   CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    assign full       = (count_reg == CNT_FULL);
    assign valid      = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/lscd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_back
// Frame engine: carries out fills, pixel writes, runs and reads on the frame
// store and delivers one result beat per work item.
// ----------------------------------------------------------------------------
module lscd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  lscd_pkg::queue_entry_t          q_entry,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lscd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import lscd_pkg::*;

    back_state_t  state_reg, state_next;
    queue_entry_t work_reg;
    logic [15:0]  pos_reg;
    logic [7:0]   left_reg;
    logic [PIXEL_COUNT-1:0] pix_valid_reg;
    logic         rd_valid_reg;
    logic         out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              out_free;
    logic              idx_in_range;
    logic              pos_in_range;
    logic              ram_we;
    logic [PIX_AW-1:0] ram_waddr;
    logic              ram_re;
    logic [RGB_W-1:0]  ram_rdata;
    logic              load_out;
    logic              read_valid;
    logic [RGB_W-1:0]  read_rgb;

    assign out_free     = !out_valid_reg || m_tready;
    assign idx_in_range = (work_reg.index < PIX_LIMIT);
    assign pos_in_range = (pos_reg < PIX_LIMIT);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    unique case (q_entry.kind)
                        K_READ:  state_next = BK_READ;
                        K_SET:   state_next = BK_SET;
                        K_FILL:  state_next = BK_FILL;
                        K_RUN:   state_next = BK_RUN;
                        default: state_next = BK_FINISH;
                    endcase
                end
            end
            BK_SET:  state_next = BK_FINISH;
            BK_READ: state_next = BK_FINISH;
            BK_FILL: begin
                if (pos_reg == PIX_LAST) begin
                    state_next = BK_FINISH;
                end
            end
            BK_RUN: begin
                // stop when the run is spent or has left the strip
                if (left_reg == 8'd0 || !pos_in_range) begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pos_reg[PIX_AW-1:0];
        ram_re    = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop = q_valid;
            BK_SET: begin
                ram_we    = idx_in_range;
                ram_waddr = work_reg.index[PIX_AW-1:0];
            end
            BK_READ:   ram_re   = idx_in_range;
            BK_FILL:   ram_we   = 1'b1;
            BK_RUN:    ram_we   = (left_reg != 8'd0) && pos_in_range;
            BK_FINISH: load_out = out_free;
            default: ;
        endcase
    end

    lscd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PIXEL_COUNT)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (work_reg.rgb),
        .re    (ram_re),
        .raddr (work_reg.index[PIX_AW-1:0]),
        .rdata (ram_rdata)
    );

    // an entry never written since reset reads as black
    assign read_valid = (work_reg.kind == K_READ) && idx_in_range;
    assign read_rgb   = (read_valid && rd_valid_reg) ? ram_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            pix_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ram_we) begin
                pix_valid_reg[ram_waddr] <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_entry;
            pos_reg  <= (q_entry.kind == K_FILL) ? 16'd0 : q_entry.index;
            left_reg <= q_entry.run;
        end else if (ram_we && (state_reg == BK_FILL || state_reg == BK_RUN)) begin
            pos_reg  <= pos_reg + 16'd1;
            left_reg <= left_reg - 8'd1;
        end
        if (ram_re) begin
            rd_valid_reg <= pix_valid_reg[work_reg.index[PIX_AW-1:0]];
        end
        if (load_out) begin
            out_data_reg <= {5'd0, read_rgb[7:0], read_rgb[15:8], read_rgb[23:16],
                             read_valid, work_reg.brightness,
                             work_reg.bad_sig, work_reg.updated};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: src/led_strip_command_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_command_decoder
// Parses serial header and payload bytes into LED frame commands and keeps
// the frame store; read beats return one stored pixel.
//
//   Channel   Ports                       Beat contents
//   s_        tvalid tready tdata tuser   tuser: opcode; tdata: byte, read index
//   m_        tvalid tready tdata         flags, brightness, read pixel
//   cfg_      we index wdata              0 header_big_endian, 1 rle_start_index
//
// Every beat in gives exactly one result beat, in order. The parser takes a
// beat per cycle while its four-entry queue has room; the frame engine ends
// one work item before it takes the next. A fill writes all PIXEL_COUNT
// pixels and a run chunk min(run, PIXEL_COUNT - start, clipped at zero)
// pixels, one by one through the single write port of the frame store.
// Reset clears the store at once through per-pixel valid flags. A stalled m_
// side holds the engine; the parser runs on until the queue is full.
// ----------------------------------------------------------------------------
module led_strip_command_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] data_byte, [15:8] read_index
    input  logic [lscd_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] opcode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] frame_updated, [1] bad_signature, [9:2] brightness_level,
    // [10] read_valid, [18:11] pixel_red, [26:19] pixel_green,
    // [34:27] pixel_blue, [39:35] zero
    output logic [lscd_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [lscd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lscd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lscd_pkg::*;

    logic         push;
    queue_entry_t push_entry;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    queue_entry_t head_entry;

    lscd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    lscd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (head_entry)
    );

    lscd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
